>>> rtl/core/fmp_pkg.sv
package fmp_pkg;

	// Sync bytes that open every frame.
	localparam logic [7:0] SYNC_FIRST  = 8'h42;
	localparam logic [7:0] SYNC_SECOND = 8'h52;

	// Parser phases, one-hot.
	typedef enum logic [10:0] {
		PH_SYNC1   = 11'b000_0000_0001,
		PH_SYNC2   = 11'b000_0000_0010,
		PH_LEN_L   = 11'b000_0000_0100,
		PH_LEN_H   = 11'b000_0000_1000,
		PH_ID_L    = 11'b000_0001_0000,
		PH_ID_H    = 11'b000_0010_0000,
		PH_SRC     = 11'b000_0100_0000,
		PH_DST     = 11'b000_1000_0000,
		PH_PAYLOAD = 11'b001_0000_0000,
		PH_CK_L    = 11'b010_0000_0000,
		PH_CK_H    = 11'b100_0000_0000
	} fmp_phase_t;

	// One finished frame.
	typedef struct packed {
		logic        frame_status;
		logic [15:0] message_id;
		logic [15:0] payload_length;
		logic [31:0] good_frames;
		logic [31:0] bad_frames;
	} fmp_result_t;

	// Contents of the input stage.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} fmp_stage_t;

endpackage

>>> rtl/core/fmp_byte_if.sv
interface fmp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/fmp_result_if.sv
interface fmp_result_if;
	logic        valid;
	logic        ready;
	logic        frame_status;
	logic [15:0] message_id;
	logic [15:0] payload_length;
	logic [31:0] good_frames;
	logic [31:0] bad_frames;

	modport source (output valid, output frame_status, output message_id,
		output payload_length, output good_frames, output bad_frames, input ready);
	modport sink (input valid, input frame_status, input message_id,
		input payload_length, input good_frames, input bad_frames, output ready);
endinterface

>>> rtl/core/fmp_in_stage.sv
module fmp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	input  logic [7:0]         rx_data,
	output logic               rx_ready,
	input  logic               advance,
	output fmp_pkg::fmp_stage_t stage
);
	import fmp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;

	// The stage takes a new word whenever it is empty or its word moves on.
	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && rx_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// The byte itself needs no reset.
	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_data;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.data  = byte_s1;
endmodule

>>> rtl/core/fmp_parse.sv
module fmp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          rx_data,
	output logic                frame_done,
	output fmp_pkg::fmp_result_t result
);
	import fmp_pkg::*;

	fmp_phase_t  phase_q, phase_d;
	logic [15:0] left_q, left_d;
	logic [15:0] length_q, length_d;
	logic [15:0] id_q, id_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  ck_low_q, ck_low_d;
	logic [31:0] good_q, good_d;
	logic [31:0] bad_q, bad_d;
	logic [15:0] sum_add;
	logic [15:0] left_dec;
	logic [15:0] received;
	logic        bad;

	assign sum_add  = sum_q + {8'h00, rx_data};
	assign left_dec = (left_q != 16'h0000) ? (left_q - 16'h0001) : left_q;
	assign received = {rx_data, ck_low_q};
	assign bad      = (received != sum_q);

	// Next state for the word in the input stage.
	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		length_d   = length_q;
		id_d       = id_q;
		sum_d      = sum_q;
		ck_low_d   = ck_low_q;
		good_d     = good_q;
		bad_d      = bad_q;
		frame_done = 1'b0;
		case (phase_q)
			PH_SYNC2: begin
				if (rx_data == SYNC_SECOND) begin
					sum_d   = sum_add;
					phase_d = PH_LEN_L;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_LEN_L: begin
				sum_d    = sum_add;
				length_d = {8'h00, rx_data};
				phase_d  = PH_LEN_H;
			end
			PH_LEN_H: begin
				sum_d    = sum_add;
				length_d = {rx_data, length_q[7:0]};
				phase_d  = PH_ID_L;
			end
			PH_ID_L: begin
				sum_d   = sum_add;
				id_d    = {8'h00, rx_data};
				phase_d = PH_ID_H;
			end
			PH_ID_H: begin
				sum_d   = sum_add;
				id_d    = {rx_data, id_q[7:0]};
				phase_d = PH_SRC;
			end
			PH_SRC: begin
				sum_d   = sum_add;
				phase_d = PH_DST;
			end
			PH_DST: begin
				sum_d   = sum_add;
				left_d  = length_q;
				phase_d = (length_q == 16'h0000) ? PH_CK_L : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				// A word that finds no payload left is dropped.
				if (left_q != 16'h0000) begin
					sum_d = sum_add;
				end
				left_d = left_dec;
				if (left_dec == 16'h0000) begin
					phase_d = PH_CK_L;
				end
			end
			PH_CK_L: begin
				ck_low_d = rx_data;
				phase_d  = PH_CK_H;
			end
			PH_CK_H: begin
				frame_done = 1'b1;
				if (bad) begin
					bad_d = bad_q + 32'd1;
				end else begin
					good_d = good_q + 32'd1;
				end
				phase_d  = PH_SYNC1;
				left_d   = 16'h0000;
				length_d = 16'h0000;
				id_d     = 16'h0000;
				sum_d    = 16'h0000;
				ck_low_d = 8'h00;
			end
			default: begin
				// Hunting for the first sync byte.
				phase_d = PH_SYNC1;
				if (rx_data == SYNC_FIRST) begin
					sum_d   = {8'h00, rx_data};
					phase_d = PH_SYNC2;
				end
			end
		endcase
	end

	// The finished frame as seen on the checksum high byte.
	assign result.frame_status   = bad;
	assign result.message_id     = id_q;
	assign result.payload_length = length_q;
	assign result.good_frames    = good_d;
	assign result.bad_frames     = bad_d;

	// Parser state advances once for each word that leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			left_q   <= 16'h0000;
			length_q <= 16'h0000;
			id_q     <= 16'h0000;
			sum_q    <= 16'h0000;
			ck_low_q <= 8'h00;
			good_q   <= 32'h0000_0000;
			bad_q    <= 32'h0000_0000;
		end else if (advance) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			length_q <= length_d;
			id_q     <= id_d;
			sum_q    <= sum_d;
			ck_low_q <= ck_low_d;
			good_q   <= good_d;
			bad_q    <= bad_d;
		end
	end
endmodule

>>> rtl/core/fmp_out_reg.sv
module fmp_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  fmp_pkg::fmp_result_t result,
	output logic                free,
	output logic                res_valid,
	input  logic                res_ready,
	output fmp_pkg::fmp_result_t res_data
);
	import fmp_pkg::*;

	logic        valid_q;
	fmp_result_t data_q;

	// The register can take a frame if it is empty or being emptied now.
	assign free = !valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign res_valid = valid_q;
	assign res_data  = data_q;
endmodule

>>> rtl/core/framed_message_parser_core.sv
// Channel  Role   Word
// rx       sink   one received byte (rx_byte)
// res      source one finished frame (status, id, length, good/bad counts)
//
// One byte is taken per cycle unless a frame waits on a full output register. A byte is
// registered in the input stage; as it leaves, parser state and any frame result load.
// Reset is asynchronous and clears the parser and both stages; no clearing pass follows.
// Only the checksum high byte waits on a full output register; every other byte
// moves on regardless of res.ready.
module framed_message_parser_core (
	input logic        clk,
	input logic        arst_n,
	fmp_byte_if.sink   rx,
	fmp_result_if.source res
);
	import fmp_pkg::*;

	fmp_stage_t  stage;
	fmp_result_t result;
	fmp_result_t res_data;
	logic        frame_done;
	logic        out_free;
	logic        advance;

	// The staged byte moves on unless it finishes a frame that cannot be stored.
	assign advance = stage.valid && (!frame_done || out_free);

	fmp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_data  (rx.rx_byte),
		.rx_ready (rx.ready),
		.advance  (advance),
		.stage    (stage)
	);

	fmp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.rx_data    (stage.data),
		.frame_done (frame_done),
		.result     (result)
	);

	fmp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && frame_done),
		.result    (result),
		.free      (out_free),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.res_data  (res_data)
	);

	assign res.frame_status   = res_data.frame_status;
	assign res.message_id     = res_data.message_id;
	assign res.payload_length = res_data.payload_length;
	assign res.good_frames    = res_data.good_frames;
	assign res.bad_frames     = res_data.bad_frames;
endmodule

>>> bench/framed_message_parser_core_tb.sv
module framed_message_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fmp_pkg::*;

	localparam int RANDOM_WORDS  = 1150;
	localparam int STALL_LIMIT   = 1000;
	localparam int FULL_FRAME    = 32'h7fff_ffff;

	// Frame tracker: follows the byte stream and holds the frames still to come out.
	class frame_scoreboard;
		fmp_phase_t  phase;
		logic [15:0] bytes_left;
		logic [15:0] frame_length;
		logic [15:0] frame_id;
		logic [15:0] running_sum;
		logic [7:0]  check_low;
		logic [31:0] good_count;
		logic [31:0] bad_count;
		fmp_result_t expected_frames[$];
		int          bytes_taken;
		int          frames_checked;
		int          errors;

		function new();
			phase          = PH_SYNC1;
			bytes_left     = '0;
			frame_length   = '0;
			frame_id       = '0;
			running_sum    = '0;
			check_low      = '0;
			good_count     = '0;
			bad_count      = '0;
			bytes_taken    = 0;
			frames_checked = 0;
			errors         = 0;
		endfunction

		// Advance the parse state by one accepted word.
		function void note_byte(logic [7:0] b);
			fmp_result_t fr;
			logic [15:0] received;
			bytes_taken++;
			case (phase)
			PH_SYNC2: begin
				// A wrong second sync byte drops back to the hunt without a recheck.
				if (b == SYNC_SECOND) begin
					running_sum = running_sum + {8'h00, b};
					phase = PH_LEN_L;
				end else begin
					phase = PH_SYNC1;
				end
			end
			PH_LEN_L: begin
				running_sum = running_sum + {8'h00, b};
				frame_length = {8'h00, b};
				phase = PH_LEN_H;
			end
			PH_LEN_H: begin
				running_sum = running_sum + {8'h00, b};
				frame_length = {b, frame_length[7:0]};
				phase = PH_ID_L;
			end
			PH_ID_L: begin
				running_sum = running_sum + {8'h00, b};
				frame_id = {8'h00, b};
				phase = PH_ID_H;
			end
			PH_ID_H: begin
				running_sum = running_sum + {8'h00, b};
				frame_id = {b, frame_id[7:0]};
				phase = PH_SRC;
			end
			PH_SRC: begin
				running_sum = running_sum + {8'h00, b};
				phase = PH_DST;
			end
			PH_DST: begin
				running_sum = running_sum + {8'h00, b};
				bytes_left = frame_length;
				phase = (frame_length == 16'd0) ? PH_CK_L : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (bytes_left != 16'd0) begin
					running_sum = running_sum + {8'h00, b};
					bytes_left = bytes_left - 16'd1;
				end
				if (bytes_left == 16'd0) begin
					phase = PH_CK_L;
				end
			end
			PH_CK_L: begin
				check_low = b;
				phase = PH_CK_H;
			end
			PH_CK_H: begin
				// The frame closes here and yields one result.
				received = {b, check_low};
				fr.frame_status = (received != running_sum);
				if (fr.frame_status) begin
					bad_count = bad_count + 32'd1;
				end else begin
					good_count = good_count + 32'd1;
				end
				fr.message_id     = frame_id;
				fr.payload_length = frame_length;
				fr.good_frames    = good_count;
				fr.bad_frames     = bad_count;
				expected_frames.push_back(fr);
				phase        = PH_SYNC1;
				bytes_left   = '0;
				frame_length = '0;
				frame_id     = '0;
				running_sum  = '0;
				check_low    = '0;
			end
			default: begin
				// Hunting: anything but the first sync byte is ignored.
				phase = PH_SYNC1;
				if (b == SYNC_FIRST) begin
					running_sum = {8'h00, b};
					phase = PH_SYNC2;
				end
			end
			endcase
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("[%0t] frame %0d: %s is 0x%0h, expected 0x%0h",
				$realtime, frames_checked, what, got, want);
			errors++;
		endtask

		// Compare one finished frame with the oldest one predicted.
		task check_frame(fmp_result_t got);
			fmp_result_t want;
			if (expected_frames.size() == 0) begin
				report_mismatch("unexpected frame, id", {16'h0, got.message_id}, 32'h0);
			end else begin
				want = expected_frames.pop_front();
				if (got.frame_status !== want.frame_status)
					report_mismatch("frame_status", {31'h0, got.frame_status},
						{31'h0, want.frame_status});
				if (got.message_id !== want.message_id)
					report_mismatch("message_id", {16'h0, got.message_id},
						{16'h0, want.message_id});
				if (got.payload_length !== want.payload_length)
					report_mismatch("payload_length", {16'h0, got.payload_length},
						{16'h0, want.payload_length});
				if (got.good_frames !== want.good_frames)
					report_mismatch("good_frames", got.good_frames, want.good_frames);
				if (got.bad_frames !== want.bad_frames)
					report_mismatch("bad_frames", got.bad_frames, want.bad_frames);
			end
			frames_checked++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	fmp_byte_if   rx_ch ();
	fmp_result_if res_ch ();

	frame_scoreboard sb = new();
	bit rx_burst;
	int idle_cycles = 0;

	framed_message_parser_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap before a word: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (rx_burst || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Payload bytes lean toward the extremes and the sync values.
	function automatic logic [7:0] pick_payload();
		case ($urandom_range(0, 9))
		0: return 8'h00;
		1: return 8'hff;
		2: return SYNC_FIRST;
		3: return SYNC_SECOND;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one word and hold it until it is taken.
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!(rx_ch.valid && rx_ch.ready));
		sb.note_byte(b);
	endtask

	// Send a frame, optionally with a bad checksum or cut short after cut bytes.
	// A cut frame is closed by random filler so that the parser is hunting again.
	task automatic send_frame(logic [15:0] len, logic [15:0] id, bit corrupt, int cut);
		logic [7:0]  fbytes[$];
		logic [15:0] sum;
		sum = '0;
		fbytes.push_back(SYNC_FIRST);
		fbytes.push_back(SYNC_SECOND);
		fbytes.push_back(len[7:0]);
		fbytes.push_back(len[15:8]);
		fbytes.push_back(id[7:0]);
		fbytes.push_back(id[15:8]);
		fbytes.push_back(8'($urandom_range(0, 255)));
		fbytes.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < len; i++)
			fbytes.push_back(pick_payload());
		foreach (fbytes[i])
			sum = sum + {8'h00, fbytes[i]};
		if (corrupt)
			sum = sum ^ 16'($urandom_range(1, 65535));
		fbytes.push_back(sum[7:0]);
		fbytes.push_back(sum[15:8]);
		for (int i = 0; i < fbytes.size() && i < cut; i++)
			send_byte(fbytes[i]);
		while (sb.phase != PH_SYNC1)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 16'($urandom_range(0, 8));
		else if (r < 98)
			return 16'($urandom_range(9, 40));
		else
			return 16'($urandom_range(256, 270));
	endfunction

	// Result side: accept in runs, with short stalls, long stalls and open stretches.
	initial begin
		int on_cycles;
		int off_cycles;
		int r;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				on_cycles  = $urandom_range(50, 150);
				off_cycles = 0;
			end else if (r < 85) begin
				on_cycles  = $urandom_range(1, 12);
				off_cycles = $urandom_range(1, 3);
			end else begin
				on_cycles  = $urandom_range(1, 6);
				off_cycles = $urandom_range(10, 40);
			end
			res_ch.ready <= 1'b1;
			repeat (on_cycles) @(posedge clk);
			if (off_cycles > 0) begin
				res_ch.ready <= 1'b0;
				repeat (off_cycles) @(posedge clk);
			end
		end
	end

	// Check every frame the block hands over.
	always @(posedge clk) begin
		fmp_result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.frame_status   = res_ch.frame_status;
			got.message_id     = res_ch.message_id;
			got.payload_length = res_ch.payload_length;
			got.good_frames    = res_ch.good_frames;
			got.bad_frames     = res_ch.bad_frames;
			sb.check_frame(got);
		end
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("framed_message_parser_core regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: directed frames first, then random traffic.
	initial begin
		int r;
		logic [7:0] b;
		rx_burst       = 1'b0;
		arst_n         <= 1'b0;
		rx_ch.valid    <= 1'b0;
		rx_ch.rx_byte  <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Noise before sync, then a repeated first sync byte that must not resync.
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(SYNC_SECOND);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		// Empty payload with a good sum, then one payload byte with a bad sum.
		send_frame(16'd0, 16'hffff, 1'b0, FULL_FRAME);
		send_frame(16'd1, 16'h0000, 1'b1, FULL_FRAME);

		while (sb.bytes_taken < RANDOM_WORDS) begin
			rx_burst = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_frame(pick_length(), 16'($urandom_range(0, 65535)), 1'b0, FULL_FRAME);
			end else if (r < 82) begin
				send_frame(pick_length(), 16'($urandom_range(0, 65535)), 1'b1, FULL_FRAME);
			end else if (r < 90) begin
				send_frame(16'($urandom_range(0, 8)), 16'($urandom_range(0, 65535)),
					1'b0, $urandom_range(6, 12));
			end else if (r < 95) begin
				// Broken sync pair.
				b = 8'($urandom_range(0, 255));
				if (b == SYNC_SECOND)
					b = 8'h00;
				send_byte(SYNC_FIRST);
				send_byte(b);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					b = 8'($urandom_range(0, 255));
					if (b == SYNC_FIRST)
						b = 8'h41;
					send_byte(b);
				end
			end
		end
		rx_ch.valid <= 1'b0;

		// Drain, then let the pipeline settle.
		while (sb.expected_frames.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.errors == 0 && sb.expected_frames.size() == 0) begin
			$display("framed_message_parser_core regression: pass");
		end else begin
			$display("framed_message_parser_core regression: fail");
		end
		$finish;
	end

endmodule
